// ===== hw/rtl/scit_pkg.sv =====
// Shared definitions for the sphere against segment or capsule test unit.
// Holds default sizes, the region code, queue status and the queue entry size.
// No dependencies.
`default_nettype none

package scit_pkg;

	localparam int COORD_BITS_DEF  = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Which part of the segment the sphere center projects onto.
	typedef enum logic [1:0] {
		REGION_START    = 2'd0,
		REGION_END      = 2'd1,
		REGION_INTERIOR = 2'd2
	} region_t;

	// Status of the queue between the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Width of one queue entry: region, endpoint hit, A, B, |d|, sign of d,
	// dot, len2, |C-A|^2 and r^2.
	function automatic int entry_bits(input int cb);
		int sumw;
		sumw = 2 * cb + 2;
		return 2 + 1 + 9 * cb + 3 + 3 * sumw + 2 * cb;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sphere_capsule_intersect_test_unit.sv =====
// Sphere against segment or capsule intersection test, top level.
// Depends on scit_pkg, scit_front, scit_fifo, scit_back and scit_div.
//
// Usage: each request on the input channel (in_valid / in_stall) carries a
// sphere center and radius, the two segment endpoints A and B and a capsule
// radius (zero for a plain line). One result per request leaves on the
// output channel (out_valid / out_stall): hit flag, region (start point, end
// point or interior) and contact point, which is zero when nothing is hit.
// A request is taken on a rising edge with valid high and stall low.
//
// Throughput is one request per clock while in_stall is low. A request
// passes through the front stage loaded by the accepting edge, two further
// front stages, the queue, two back stages, the COORD_BITS stages of the
// restoring divider that forms the interior contact point, one quotient
// bit per stage, and the output register.
//
// The front computes differences, squares and the dot product and picks the
// region; it hands its work to the back through a QUEUE_DEPTH entry queue.
// When the receiver stalls an offered result, the back pipeline and its
// output register hold; the front keeps taking requests until the queue is
// full and then raises in_stall. Reset empties the queue and clears every
// valid flag; no result is offered until a new request arrives.
`default_nettype none

module sphere_capsule_intersect_test_unit #(
	parameter int COORD_BITS  = scit_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = scit_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic signed [COORD_BITS-1:0]  center_z,
	input  logic        [COORD_BITS-2:0]  sphere_radius,
	input  logic signed [COORD_BITS-1:0]  seg_a_x,
	input  logic signed [COORD_BITS-1:0]  seg_a_y,
	input  logic signed [COORD_BITS-1:0]  seg_a_z,
	input  logic signed [COORD_BITS-1:0]  seg_b_x,
	input  logic signed [COORD_BITS-1:0]  seg_b_y,
	input  logic signed [COORD_BITS-1:0]  seg_b_z,
	input  logic        [COORD_BITS-2:0]  capsule_radius,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [1:0]                    region,
	output logic signed [COORD_BITS-1:0]  hit_x,
	output logic signed [COORD_BITS-1:0]  hit_y,
	output logic signed [COORD_BITS-1:0]  hit_z
);

	// Width of one queue entry, shared with the front and the back.
	localparam int ENT_BITS = scit_pkg::entry_bits(COORD_BITS);

	scit_pkg::qstat_t      qstat;
	logic                  push;
	logic                  pop;
	logic [ENT_BITS-1:0]   wr_ent;
	logic [ENT_BITS-1:0]   rd_ent;

	scit_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.center_x       (center_x),
		.center_y       (center_y),
		.center_z       (center_z),
		.sphere_radius  (sphere_radius),
		.seg_a_x        (seg_a_x),
		.seg_a_y        (seg_a_y),
		.seg_a_z        (seg_a_z),
		.seg_b_x        (seg_b_x),
		.seg_b_y        (seg_b_y),
		.seg_b_z        (seg_b_z),
		.capsule_radius (capsule_radius),
		.qstat          (qstat),
		.push           (push),
		.ent            (wr_ent)
	);

	// The queue lets the front keep working while the receiver stalls.
	scit_fifo #(
		.WIDTH (ENT_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_ent),
		.pop    (pop),
		.rdata  (rd_ent),
		.stat   (qstat)
	);

	scit_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop       (pop),
		.ent       (rd_ent),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.region    (region),
		.hit_x     (hit_x),
		.hit_y     (hit_y),
		.hit_z     (hit_z)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/scit_fifo.sv =====
// Short request queue that decouples the front from the back.
// Depends on scit_pkg for the status struct.
`default_nettype none

module scit_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = scit_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                pop,
	output logic [WIDTH-1:0]    rdata,
	output scit_pkg::qstat_t    stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("request queue written while full");

	ap_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("request queue read while empty");

	ap_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("request queue count lost a write");

	ap_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("request queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/scit_front.sv =====
// Front part: takes requests, forms differences, squares and dot product,
// classifies the region and decides endpoint hits. Depends on scit_pkg.
`default_nettype none

module scit_front #(
	parameter int COORD_BITS = scit_pkg::COORD_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic signed [COORD_BITS-1:0]                  center_x,
	input  logic signed [COORD_BITS-1:0]                  center_y,
	input  logic signed [COORD_BITS-1:0]                  center_z,
	input  logic        [COORD_BITS-2:0]                  sphere_radius,
	input  logic signed [COORD_BITS-1:0]                  seg_a_x,
	input  logic signed [COORD_BITS-1:0]                  seg_a_y,
	input  logic signed [COORD_BITS-1:0]                  seg_a_z,
	input  logic signed [COORD_BITS-1:0]                  seg_b_x,
	input  logic signed [COORD_BITS-1:0]                  seg_b_y,
	input  logic signed [COORD_BITS-1:0]                  seg_b_z,
	input  logic        [COORD_BITS-2:0]                  capsule_radius,
	input  scit_pkg::qstat_t                              qstat,
	output logic                                          push,
	output logic [scit_pkg::entry_bits(COORD_BITS)-1:0]   ent
);

	localparam int CB   = COORD_BITS;
	localparam int DW   = CB + 1;
	localparam int SUMW = 2 * CB + 2;
	localparam int DOTW = SUMW + 1;

	typedef struct packed {
		scit_pkg::region_t     region;
		logic                  hit;
		logic [2:0][CB-1:0]    a;
		logic [2:0][CB-1:0]    b;
		logic [2:0][CB-1:0]    dmag;
		logic [2:0]            dneg;
		logic [SUMW-1:0]       dot;
		logic [SUMW-1:0]       len2;
		logic [SUMW-1:0]       v1sq;
		logic [2*CB-1:0]       r2;
	} qent_t;

	logic en;
	logic v_s1, v_s2, v_s3;

	logic signed [CB-1:0] c_in [3];
	logic signed [CB-1:0] a_in [3];
	logic signed [CB-1:0] b_in [3];

	assign c_in[0] = center_x;
	assign c_in[1] = center_y;
	assign c_in[2] = center_z;
	assign a_in[0] = seg_a_x;
	assign a_in[1] = seg_a_y;
	assign a_in[2] = seg_a_z;
	assign b_in[0] = seg_b_x;
	assign b_in[1] = seg_b_y;
	assign b_in[2] = seg_b_z;

	assign en       = !(v_s3 && qstat.full);
	assign in_stall = !en;
	assign push     = v_s3 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: differences and radius sum.
	logic signed [DW-1:0] d_s1  [3];
	logic signed [DW-1:0] v1_s1 [3];
	logic signed [DW-1:0] v2_s1 [3];
	logic signed [CB-1:0] a_s1  [3];
	logic signed [CB-1:0] b_s1  [3];
	logic        [CB-1:0] r_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DW'(b_in[i]) - DW'(a_in[i]);
				v1_s1[i] <= DW'(c_in[i]) - DW'(a_in[i]);
				v2_s1[i] <= DW'(c_in[i]) - DW'(b_in[i]);
				a_s1[i]  <= a_in[i];
				b_s1[i]  <= b_in[i];
			end
			r_s1 <= CB'(sphere_radius) + CB'(capsule_radius);
		end
	end

	// Stage 2: component products.
	logic signed [2*DW-1:0] pdd [3];
	logic signed [2*DW-1:0] pq1 [3];
	logic signed [2*DW-1:0] pq2 [3];
	logic signed [2*DW-1:0] pdv [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pdd[i] = d_s1[i] * d_s1[i];
			pq1[i] = v1_s1[i] * v1_s1[i];
			pq2[i] = v2_s1[i] * v2_s1[i];
			pdv[i] = d_s1[i] * v1_s1[i];
		end
	end

	logic        [2*CB-1:0] dd_s2   [3];
	logic        [2*CB-1:0] q1_s2   [3];
	logic        [2*CB-1:0] q2_s2   [3];
	logic signed [2*DW-1:0] dv_s2   [3];
	logic        [CB-1:0]   dmag_s2 [3];
	logic        [2:0]      dneg_s2;
	logic signed [CB-1:0]   a_s2    [3];
	logic signed [CB-1:0]   b_s2    [3];
	logic        [2*CB-1:0] r2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i]   <= pdd[i][2*CB-1:0];
				q1_s2[i]   <= pq1[i][2*CB-1:0];
				q2_s2[i]   <= pq2[i][2*CB-1:0];
				dv_s2[i]   <= pdv[i];
				dmag_s2[i] <= d_s1[i][DW-1] ? CB'(-d_s1[i]) : CB'(d_s1[i]);
				dneg_s2[i] <= d_s1[i][DW-1];
				a_s2[i]    <= a_s1[i];
				b_s2[i]    <= b_s1[i];
			end
			r2_s2 <= r_s1 * r_s1;
		end
	end

	// Stage 3: sums of the three axes.
	logic        [SUMW-1:0] len2_s3;
	logic        [SUMW-1:0] v1sq_s3;
	logic        [SUMW-1:0] v2sq_s3;
	logic signed [DOTW-1:0] dot_s3;
	logic        [2*CB-1:0] r2_s3;
	logic        [CB-1:0]   dmag_s3 [3];
	logic        [2:0]      dneg_s3;
	logic signed [CB-1:0]   a_s3    [3];
	logic signed [CB-1:0]   b_s3    [3];

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s3 <= SUMW'(dd_s2[0]) + SUMW'(dd_s2[1]) + SUMW'(dd_s2[2]);
			v1sq_s3 <= SUMW'(q1_s2[0]) + SUMW'(q1_s2[1]) + SUMW'(q1_s2[2]);
			v2sq_s3 <= SUMW'(q2_s2[0]) + SUMW'(q2_s2[1]) + SUMW'(q2_s2[2]);
			dot_s3  <= DOTW'(dv_s2[0]) + DOTW'(dv_s2[1]) + DOTW'(dv_s2[2]);
			r2_s3   <= r2_s2;
			dneg_s3 <= dneg_s2;
			for (int i = 0; i < 3; i++) begin
				dmag_s3[i] <= dmag_s2[i];
				a_s3[i]    <= a_s2[i];
				b_s3[i]    <= b_s2[i];
			end
		end
	end

	// Region decision. A zero-length segment has dot equal to zero and so
	// lands on the start point.
	logic              dot_le0;
	logic              dot_ge;
	scit_pkg::region_t reg_c;
	logic              hit_c;
	qent_t             e;

	assign dot_le0 = dot_s3[DOTW-1] || (dot_s3 == '0);
	assign dot_ge  = (dot_s3[SUMW-1:0] >= len2_s3);

	always_comb begin
		if (dot_le0) begin
			reg_c = scit_pkg::REGION_START;
			hit_c = (v1sq_s3 <= SUMW'(r2_s3));
		end else if (dot_ge) begin
			reg_c = scit_pkg::REGION_END;
			hit_c = (v2sq_s3 <= SUMW'(r2_s3));
		end else begin
			reg_c = scit_pkg::REGION_INTERIOR;
			hit_c = 1'b0;
		end
	end

	always_comb begin
		e.region = reg_c;
		e.hit    = hit_c;
		for (int i = 0; i < 3; i++) begin
			e.a[i]    = a_s3[i];
			e.b[i]    = b_s3[i];
			e.dmag[i] = dmag_s3[i];
		end
		e.dneg = dneg_s3;
		e.dot  = dot_s3[SUMW-1:0];
		e.len2 = len2_s3;
		e.v1sq = v1sq_s3;
		e.r2   = r2_s3;
	end

	assign ent = e;

endmodule

`default_nettype wire

// ===== hw/rtl/scit_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// The high part of the numerator must be below the divisor. No dependencies.
`default_nettype none

module scit_div #(
	parameter int QW   = 24,
	parameter int DENW = 50
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DENW+QW-1:0]   num,
	input  logic [DENW-1:0]      den,
	output logic [QW-1:0]        quo,
	output logic [DENW-1:0]      rem
);

	localparam int NW = DENW + QW;

	logic [DENW-1:0] rem_sk [QW];
	logic [QW-1:0]   quo_sk [QW];
	logic [DENW-1:0] den_sk [QW-1];
	logic [QW-1:0]   lo_sk  [QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DENW-1:0] rem_in;
		logic [DENW-1:0] den_in;
		logic [QW-1:0]   lo_in;
		logic [QW-1:0]   quo_in;
		logic [DENW:0]   trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_in = num[NW-1:QW];
			assign den_in = den;
			assign lo_in  = num[QW-1:0];
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sk[k-1];
			assign den_in = den_sk[k-1];
			assign lo_in  = lo_sk[k-1];
			assign quo_in = quo_sk[k-1];
		end

		assign trial = {rem_in, lo_in[QW-1]};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k] <= ge ? DENW'(trial - {1'b0, den_in}) : trial[DENW-1:0];
				quo_sk[k] <= {quo_in[QW-2:0], ge};
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					den_sk[k] <= den_in;
					lo_sk[k]  <= {lo_in[QW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_sk[QW-1];
	assign rem = rem_sk[QW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/scit_back.sv =====
// Back part: interior distance test on split products, contact point by
// division, and the output register. Depends on scit_pkg and scit_div.
`default_nettype none

module scit_back #(
	parameter int COORD_BITS = scit_pkg::COORD_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  scit_pkg::qstat_t                              qstat,
	output logic                                          pop,
	input  logic [scit_pkg::entry_bits(COORD_BITS)-1:0]   ent,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output logic                                          hit,
	output logic [1:0]                                    region,
	output logic signed [COORD_BITS-1:0]                  hit_x,
	output logic signed [COORD_BITS-1:0]                  hit_y,
	output logic signed [COORD_BITS-1:0]                  hit_z
);

	localparam int CB   = COORD_BITS;
	localparam int SUMW = 2 * CB + 2;
	localparam int H    = CB + 1;
	localparam int PW   = 2 * SUMW;
	localparam int RHW  = PW + 1;
	localparam int NW   = SUMW + CB;
	localparam int SW   = CB + 2;

	typedef struct packed {
		scit_pkg::region_t     region;
		logic                  hit;
		logic [2:0][CB-1:0]    a;
		logic [2:0][CB-1:0]    b;
		logic [2:0][CB-1:0]    dmag;
		logic [2:0]            dneg;
		logic [SUMW-1:0]       dot;
		logic [SUMW-1:0]       len2;
		logic [SUMW-1:0]       v1sq;
		logic [2*CB-1:0]       r2;
	} qent_t;

	typedef struct packed {
		scit_pkg::region_t     region;
		logic                  hit;
		logic [2:0][CB-1:0]    a;
		logic [2:0][CB-1:0]    b;
		logic [2:0]            dneg;
		logic [2:0]            dnz;
	} ctl_t;

	qent_t e;
	ctl_t  c_in;
	logic  en;
	logic  out_valid_q;

	assign e   = ent;
	assign en  = !(out_valid_q && out_stall);
	assign pop = en && !qstat.empty;

	always_comb begin
		c_in.region = e.region;
		c_in.hit    = e.hit;
		c_in.a      = e.a;
		c_in.b      = e.b;
		c_in.dneg   = e.dneg;
		for (int i = 0; i < 3; i++) begin
			c_in.dnz[i] = (e.dmag[i] != '0);
		end
	end

	// Operands split into halves so that every multiplier stays narrow.
	logic [H-1:0] v1_hi, v1_lo, ln_hi, ln_lo, r2_hi, r2_lo, dot_hi, dot_lo;

	assign {v1_hi, v1_lo}   = e.v1sq;
	assign {ln_hi, ln_lo}   = e.len2;
	assign {r2_hi, r2_lo}   = SUMW'(e.r2);
	assign {dot_hi, dot_lo} = e.dot;

	// Stage 1: partial products.
	logic [2*H-1:0]  lh_hh_s1, lh_hl_s1, lh_lh_s1, lh_ll_s1;
	logic [2*H-1:0]  rr_hh_s1, rr_hl_s1, rr_lh_s1, rr_ll_s1;
	logic [2*H-1:0]  dd_hh_s1, dd_hl_s1, dd_ll_s1;
	logic [H+CB-1:0] nm_hi_s1 [3];
	logic [H+CB-1:0] nm_lo_s1 [3];
	logic [SUMW-1:0] len2_s1;
	ctl_t            ctl_s1;
	logic            vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lh_hh_s1 <= v1_hi * ln_hi;
			lh_hl_s1 <= v1_hi * ln_lo;
			lh_lh_s1 <= v1_lo * ln_hi;
			lh_ll_s1 <= v1_lo * ln_lo;
			rr_hh_s1 <= r2_hi * ln_hi;
			rr_hl_s1 <= r2_hi * ln_lo;
			rr_lh_s1 <= r2_lo * ln_hi;
			rr_ll_s1 <= r2_lo * ln_lo;
			dd_hh_s1 <= dot_hi * dot_hi;
			dd_hl_s1 <= dot_hi * dot_lo;
			dd_ll_s1 <= dot_lo * dot_lo;
			for (int i = 0; i < 3; i++) begin
				nm_hi_s1[i] <= dot_hi * e.dmag[i];
				nm_lo_s1[i] <= dot_lo * e.dmag[i];
			end
			len2_s1 <= e.len2;
			ctl_s1  <= c_in;
		end
	end

	// Stage 2: full products |C-A|^2*len2, r^2*len2, dot^2 and dot*|d|.
	logic [PW-1:0]   lhs_s2, rr_s2, dd_s2;
	logic [NW-1:0]   num_s2 [3];
	logic [SUMW-1:0] len2_s2;
	ctl_t            ctl_s2;
	logic            vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s2 <= (PW'(lh_hh_s1) << (2 * H)) + (PW'(lh_hl_s1) << H)
				+ (PW'(lh_lh_s1) << H) + PW'(lh_ll_s1);
			rr_s2  <= (PW'(rr_hh_s1) << (2 * H)) + (PW'(rr_hl_s1) << H)
				+ (PW'(rr_lh_s1) << H) + PW'(rr_ll_s1);
			dd_s2  <= (PW'(dd_hh_s1) << (2 * H)) + (PW'(dd_hl_s1) << (H + 1))
				+ PW'(dd_ll_s1);
			for (int i = 0; i < 3; i++) begin
				num_s2[i] <= (NW'(nm_hi_s1[i]) << H) + NW'(nm_lo_s1[i]);
			end
			len2_s2 <= len2_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	// Divider stages; index k lines up with the divider's stage k.
	logic [PW-1:0]  lhs_s3;
	logic [RHW-1:0] rhs_s3;
	ctl_t           ctl_sk [CB];
	logic           vld_sk [CB];
	ctl_t           ctl_adv;
	logic [CB-1:0]  quo [3];
	logic [SUMW-1:0] rem [3];

	for (genvar g = 0; g < 3; g++) begin : g_lane
		scit_div #(
			.QW   (CB),
			.DENW (SUMW)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s2[g]),
			.den (len2_s2),
			.quo (quo[g]),
			.rem (rem[g])
		);
	end

	// Interior hit: perpendicular distance squared below r^2, scaled by len2.
	always_comb begin
		ctl_adv = ctl_sk[0];
		if (ctl_sk[0].region == scit_pkg::REGION_INTERIOR) begin
			ctl_adv.hit = ({1'b0, lhs_s3} < rhs_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s3    <= lhs_s2;
			rhs_s3    <= RHW'(rr_s2) + RHW'(dd_s2);
			ctl_sk[0] <= ctl_s2;
			ctl_sk[1] <= ctl_adv;
			for (int k = 2; k < CB; k++) begin
				ctl_sk[k] <= ctl_sk[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k < CB; k++) begin
				vld_sk[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= pop;
			vld_s2    <= vld_s1;
			vld_sk[0] <= vld_s2;
			for (int k = 1; k < CB; k++) begin
				vld_sk[k] <= vld_sk[k-1];
			end
			out_valid_q <= vld_sk[CB-1];
		end
	end

	// Contact point. The interior point is a + t*d truncated toward zero;
	// the divider gives floor(t*|d|), which is nudged toward zero when the
	// sum crosses zero and the division was not exact.
	ctl_t                 cf;
	logic signed [SW-1:0] qv  [3];
	logic signed [SW-1:0] sv  [3];
	logic signed [CB-1:0] pnt [3];

	assign cf = ctl_sk[CB-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv[i] = signed'(SW'(quo[i]));
			if (cf.dneg[i]) begin
				qv[i] = -qv[i];
			end
			sv[i] = SW'(signed'(cf.a[i])) + qv[i];
			if (rem[i] != '0) begin
				if (cf.dnz[i] && !cf.dneg[i] && (sv[i] < 0)) begin
					sv[i] = sv[i] + SW'(1);
				end else if (cf.dneg[i] && (sv[i] > 0)) begin
					sv[i] = sv[i] - SW'(1);
				end
			end
			unique case (cf.region)
				scit_pkg::REGION_START:    pnt[i] = signed'(cf.a[i]);
				scit_pkg::REGION_END:      pnt[i] = signed'(cf.b[i]);
				scit_pkg::REGION_INTERIOR: pnt[i] = sv[i][CB-1:0];
				default:                   pnt[i] = '0;
			endcase
			if (!cf.hit) begin
				pnt[i] = '0;
			end
		end
	end

	logic                 hit_q;
	scit_pkg::region_t    region_q;
	logic signed [CB-1:0] px_q [3];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q    <= cf.hit;
			region_q <= cf.region;
			for (int i = 0; i < 3; i++) begin
				px_q[i] <= pnt[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign region    = region_q;
	assign hit_x     = px_q[0];
	assign hit_y     = px_q[1];
	assign hit_z     = px_q[2];

endmodule

`default_nettype wire

// ===== tb/sv/tb_sphere_capsule_intersect_test_unit.sv =====
// Self-checking testbench for the sphere against segment or capsule test unit.
// Depends on scit_pkg and sphere_capsule_intersect_test_unit; it holds its own
// exact-integer predictor, a queue-fed request driver and a result monitor.
`default_nettype none

module tb_sphere_capsule_intersect_test_unit;

	localparam int CB = scit_pkg::COORD_BITS_DEF;

	// One request as it is driven onto the input ports.
	typedef struct {
		logic signed [CB-1:0] cx, cy, cz;
		logic [CB-2:0]        srad;
		logic signed [CB-1:0] ax, ay, az;
		logic signed [CB-1:0] bx, by, bz;
		logic [CB-2:0]        crad;
	} sphere_req_t;

	// One result as the block reports it.
	typedef struct {
		logic                 hit;
		scit_pkg::region_t    region;
		logic signed [CB-1:0] px, py, pz;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b1;
	logic hit;
	logic [1:0] region;
	logic signed [CB-1:0] hit_x, hit_y, hit_z;

	sphere_req_t drive_req = '{default: '0};

	sphere_req_t pending_reqs[$];
	contact_t    expected_contacts[$];

	int  idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_requests = 1'b0;
	bit  req_taken = 1'b0;
	int  fail_count = 0;
	int  sent_count = 0;
	int  result_count = 0;
	int  hit_count = 0;
	int  region_seen[3] = '{0, 0, 0};

	sphere_capsule_intersect_test_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.center_x(drive_req.cx),
		.center_y(drive_req.cy),
		.center_z(drive_req.cz),
		.sphere_radius(drive_req.srad),
		.seg_a_x(drive_req.ax),
		.seg_a_y(drive_req.ay),
		.seg_a_z(drive_req.az),
		.seg_b_x(drive_req.bx),
		.seg_b_y(drive_req.by),
		.seg_b_z(drive_req.bz),
		.capsule_radius(drive_req.crad),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.region(region),
		.hit_x(hit_x),
		.hit_y(hit_y),
		.hit_z(hit_z)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Exact prediction of one request. The projection parameter is never
	// formed; instead dot and len2 are compared directly, and the interior
	// distance test is scaled by len2 so that everything stays integral.
	function automatic contact_t predict_contact(sphere_req_t q);
		longint c[3], a[3], b[3], d[3], v1[3];
		longint dot, len2, v1sq, v2sq, rad, r2, ad, s;
		logic [127:0] lhs, rhs, num, quo, rmd;
		contact_t res;
		c = '{q.cx, q.cy, q.cz};
		a = '{q.ax, q.ay, q.az};
		b = '{q.bx, q.by, q.bz};
		dot = 0; len2 = 0; v1sq = 0; v2sq = 0;
		for (int i = 0; i < 3; i++) begin
			d[i]  = b[i] - a[i];
			v1[i] = c[i] - a[i];
			dot  += d[i] * v1[i];
			len2 += d[i] * d[i];
			v1sq += v1[i] * v1[i];
			v2sq += (c[i] - b[i]) * (c[i] - b[i]);
		end
		rad = longint'(q.srad) + longint'(q.crad);
		r2 = rad * rad;
		res.px = '0; res.py = '0; res.pz = '0;
		if (dot <= 0) begin
			// Behind the start point; a zero-length segment lands here too.
			res.region = scit_pkg::REGION_START;
			res.hit = (v1sq <= r2);
			if (res.hit) begin
				res.px = q.ax; res.py = q.ay; res.pz = q.az;
			end
		end else if (dot >= len2) begin
			res.region = scit_pkg::REGION_END;
			res.hit = (v2sq <= r2);
			if (res.hit) begin
				res.px = q.bx; res.py = q.by; res.pz = q.bz;
			end
		end else begin
			res.region = scit_pkg::REGION_INTERIOR;
			lhs = 128'(v1sq) * 128'(len2);
			rhs = 128'(r2) * 128'(len2) + 128'(dot) * 128'(dot);
			res.hit = (lhs < rhs);
			if (res.hit) begin
				for (int i = 0; i < 3; i++) begin
					ad  = (d[i] < 0) ? -d[i] : d[i];
					num = 128'(dot) * 128'(ad);
					quo = num / 128'(len2);
					rmd = num % 128'(len2);
					s = (d[i] < 0) ? a[i] - longint'(quo[63:0])
						: a[i] + longint'(quo[63:0]);
					// The quotient was cut toward zero in magnitude; turn that
					// into truncation of the final coordinate toward zero.
					if (rmd != 0) begin
						if (d[i] > 0 && s < 0)
							s = s + 1;
						else if (d[i] < 0 && s > 0)
							s = s - 1;
					end
					case (i)
						0: res.px = s[CB-1:0];
						1: res.py = s[CB-1:0];
						default: res.pz = s[CB-1:0];
					endcase
				end
			end
		end
		return res;
	endfunction

	function automatic sphere_req_t build_req(int cx, int cy, int cz, int sr,
			int ax, int ay, int az, int bx, int by, int bz, int cr);
		sphere_req_t q;
		q.cx = cx[CB-1:0]; q.cy = cy[CB-1:0]; q.cz = cz[CB-1:0];
		q.srad = sr[CB-2:0];
		q.ax = ax[CB-1:0]; q.ay = ay[CB-1:0]; q.az = az[CB-1:0];
		q.bx = bx[CB-1:0]; q.by = by[CB-1:0]; q.bz = bz[CB-1:0];
		q.crad = cr[CB-2:0];
		return q;
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Most random requests are built around a segment at some scale so that
	// the center lands near it and every region sees hits and misses; the
	// rest are raw bit patterns, which also reach the field extremes.
	function automatic sphere_req_t random_req();
		sphere_req_t q;
		int kind, span, ox, oy, oz, ax, ay, az, rad, split;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			q.cx = CB'($urandom()); q.cy = CB'($urandom()); q.cz = CB'($urandom());
			q.ax = CB'($urandom()); q.ay = CB'($urandom()); q.az = CB'($urandom());
			q.bx = CB'($urandom()); q.by = CB'($urandom()); q.bz = CB'($urandom());
			q.srad = (CB-1)'($urandom()); q.crad = (CB-1)'($urandom());
			return q;
		end
		span = 1 << $urandom_range(1, 20);
		ox = jitter(1 << 22); oy = jitter(1 << 22); oz = jitter(1 << 22);
		ax = ox + jitter(span); ay = oy + jitter(span); az = oz + jitter(span);
		rad = $urandom_range(0, span);
		split = (kind == 9) ? rad : $urandom_range(0, rad);
		if (kind == 8)
			// Degenerate segment: both endpoints coincide.
			q = build_req(ox + jitter(span), oy + jitter(span), oz + jitter(span), split,
				ax, ay, az, ax, ay, az, rad - split);
		else
			q = build_req(ox + jitter(span), oy + jitter(span), oz + jitter(span), split,
				ax, ay, az, ox + jitter(span), oy + jitter(span), oz + jitter(span),
				rad - split);
		return q;
	endfunction

	task automatic queue_directed();
		int mx, mn, rmx;
		mx = (1 << (CB - 1)) - 1;
		mn = -(1 << (CB - 1));
		rmx = (1 << (CB - 1)) - 1;
		// Start point exactly at t = 0, just touching, then just missing.
		pending_reqs.push_back(build_req(0, 5, 0, 5, 0, 0, 0, 10, 0, 0, 0));
		pending_reqs.push_back(build_req(0, 5, 0, 4, 0, 0, 0, 10, 0, 0, 0));
		// End point exactly at t = 1, radius split across sphere and capsule.
		pending_reqs.push_back(build_req(10, 5, 0, 2, 0, 0, 0, 10, 0, 0, 3));
		pending_reqs.push_back(build_req(10, 5, 0, 2, 0, 0, 0, 10, 0, 0, 2));
		// Beyond both ends.
		pending_reqs.push_back(build_req(-7, 1, 1, 9, 0, 0, 0, 10, 0, 0, 0));
		pending_reqs.push_back(build_req(17, -1, 2, 9, 0, 0, 0, 10, 0, 0, 0));
		// Interior at distance 3: radius 3 misses the strict test, radius 4 hits.
		pending_reqs.push_back(build_req(5, 3, 0, 3, 0, 0, 0, 10, 0, 0, 0));
		pending_reqs.push_back(build_req(5, 3, 0, 1, 0, 0, 0, 10, 0, 0, 3));
		// Interior contacts that need truncation toward zero, both signs.
		pending_reqs.push_back(build_req(1, 1, 1, 4, -4, -3, 2, 3, 2, -5, 0));
		pending_reqs.push_back(build_req(-1, 2, 0, 5, 4, 3, -2, -3, -2, 5, 0));
		pending_reqs.push_back(build_req(0, 0, 0, 1, -3, -1, 0, 4, 1, 0, 0));
		// Zero-length segment, hit and miss.
		pending_reqs.push_back(build_req(3, 4, 0, 5, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(build_req(3, 4, 1, 5, 0, 0, 0, 0, 0, 0, 0));
		// Coordinate extremes, some with the largest radii and some with zero radius.
		pending_reqs.push_back(build_req(mx, mx, mx, rmx, mn, mn, mn, mx, mx, mx, rmx));
		pending_reqs.push_back(build_req(mn, mx, mn, rmx, mx, mn, mx, mn, mx, mn, rmx));
		pending_reqs.push_back(build_req(0, 0, 0, rmx, mn, mn, mn, mx, mx, mx, rmx));
		pending_reqs.push_back(build_req(mx, mn, 0, 0, mn, mx, 0, mx, mx, mx, 0));
		pending_reqs.push_back(build_req(0, 0, 0, 0, mx, 0, 0, mn, 0, 0, 0));
		pending_reqs.push_back(build_req(mn, mn, mn, 0, mn, mn, mn, mx, mx, mx, 0));
		pending_reqs.push_back(build_req(mx, mx, mx, 0, mn, mn, mn, mx, mx, mx, 0));
		pending_reqs.push_back(build_req(-1, -1, -1, rmx, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// Request driver: a new request goes out on the falling edge after the
	// previous one was taken; a held request stays unchanged while stalled.
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			if (pending_reqs.size() > 0 && !hold_requests &&
					int'($urandom_range(0, 99)) >= idle_pct) begin
				drive_req <= pending_reqs.pop_front();
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= (int'($urandom_range(0, 99)) < stall_pct);
	end

	// On each rising edge: predict every request taken and check every
	// result taken against the oldest prediction.
	always @(posedge clk) begin
		contact_t want;
		req_taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			expected_contacts.push_back(predict_contact(drive_req));
			sent_count++;
		end
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (expected_contacts.size() == 0) begin
				$display("%0t: unexpected result hit=%0b region=%0d point=(%0d,%0d,%0d)",
					$time, hit, region, hit_x, hit_y, hit_z);
				fail_count++;
			end else begin
				want = expected_contacts.pop_front();
				if (want.hit) hit_count++;
				region_seen[want.region]++;
				if (hit !== want.hit || region !== want.region || hit_x !== want.px ||
						hit_y !== want.py || hit_z !== want.pz) begin
					$display("%0t: mismatch expected hit=%0b region=%0d point=(%0d,%0d,%0d)",
						$time, want.hit, want.region, want.px, want.py, want.pz);
					$display("%0t:          actual   hit=%0b region=%0d point=(%0d,%0d,%0d)",
						$time, hit, region, hit_x, hit_y, hit_z);
					fail_count++;
				end
			end
		end
	end

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_contacts.size() > 0)
			@(posedge clk);
	endtask

	// Test sequence: directed requests with no idling, then random requests
	// in four idling and stalling phases, with one full drain pause in between.
	initial begin
		int idle_set[4];
		int stall_set[4];
		idle_set  = '{0, 78, 0, 31};
		stall_set = '{0, 0, 78, 31};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		queue_directed();
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_set[ph];
			stall_pct = stall_set[ph];
			for (int n = 0; n < 150; n++)
				pending_reqs.push_back(random_req());
			if (ph == 1) begin
				// Pause the sender partway through until the pipeline is empty.
				while (pending_reqs.size() > 75)
					@(posedge clk);
				hold_requests = 1'b1;
				while (in_valid || expected_contacts.size() > 0)
					@(posedge clk);
				hold_requests = 1'b0;
			end
			drain();
		end
		stall_pct = 0;
		repeat (CB + 40) @(posedge clk);
		$display("Checked %0d requests and %0d results: %0d hits;",
			sent_count, result_count, hit_count);
		$display("results by region: start %0d, end %0d, interior %0d.",
			region_seen[0], region_seen[1], region_seen[2]);
		if (fail_count == 0 && expected_contacts.size() == 0)
			$display("sphere_capsule_intersect_test_unit test passed");
		else
			$display("sphere_capsule_intersect_test_unit test failed");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("sphere_capsule_intersect_test_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sphere_capsule_intersect_test_unit.f =====
hw/rtl/scit_pkg.sv
hw/rtl/scit_fifo.sv
hw/rtl/scit_front.sv
hw/rtl/scit_div.sv
hw/rtl/scit_back.sv
hw/rtl/sphere_capsule_intersect_test_unit.sv
tb/sv/tb_sphere_capsule_intersect_test_unit.sv
